### rtl/htok_pkg.sv
// ----------------------------------------------------------------------------
// htok_pkg: shared types and constants of the HTTP request tokenizer
// Result record, result bundle, parser modes, token kinds and character codes.
// ----------------------------------------------------------------------------
package htok_pkg;

	localparam int METHOD_MAX_DEF   = 16;
	localparam int PATH_MAX_LEN_DEF = 256;
	localparam int VERSION_MAX_DEF  = 16;
	localparam int KEY_MAX_DEF      = 49;
	localparam int VALUE_MAX_DEF    = 256;
	localparam int HEADER_MAX_DEF   = 50;

	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [2:0] {
		K_METHOD,
		K_PATH,
		K_VERSION,
		K_KEY,
		K_VALUE,
		K_BODY,
		K_HDR_END,
		K_MSG_END
	} kind_t;

	typedef enum logic [2:0] {
		M_LINE_START,
		M_REQ_GAP,
		M_REQ_TOKEN,
		M_KEY,
		M_VALUE_LEAD,
		M_VALUE,
		M_BLANK,
		M_BODY
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        first;
		logic [5:0]  idx;
		logic        ok;
		logic [5:0]  total;
		logic        trunc;
		logic        run_last;
	} res_t;

	// all results caused by one input beat
	typedef struct packed {
		logic [1:0]      cnt;
		res_t [2:0]      res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] d, logic f, logic [5:0] i,
			logic ok, logic [5:0] t, logic tr);
		res_t r;
		r.kind     = k;
		r.data     = d;
		r.first    = f;
		r.idx      = i;
		r.ok       = ok;
		r.total    = t;
		r.trunc    = tr;
		r.run_last = 1'b0;
		return r;
	endfunction

endpackage

### rtl/htok_front.sv
// ----------------------------------------------------------------------------
// htok_front: byte classifier
// Parser state machine; takes one byte per cycle while the bundle queue has room and builds its result bundle.
// ----------------------------------------------------------------------------
module htok_front #(
	parameter int METHOD_MAX   = htok_pkg::METHOD_MAX_DEF,
	parameter int PATH_MAX_LEN = htok_pkg::PATH_MAX_LEN_DEF,
	parameter int VERSION_MAX  = htok_pkg::VERSION_MAX_DEF,
	parameter int KEY_MAX      = htok_pkg::KEY_MAX_DEF,
	parameter int VALUE_MAX    = htok_pkg::VALUE_MAX_DEF,
	parameter int HEADER_MAX   = htok_pkg::HEADER_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output logic                 push,
	output htok_pkg::bundle_t    bundle,
	input  htok_pkg::fifo_stat_t fstat
);
	import htok_pkg::*;

	localparam int CAP_A   = (METHOD_MAX > VERSION_MAX) ? METHOD_MAX : VERSION_MAX;
	localparam int CAP_B   = (PATH_MAX_LEN > VALUE_MAX) ? PATH_MAX_LEN : VALUE_MAX;
	localparam int CAP_C   = (CAP_A > CAP_B) ? CAP_A : CAP_B;
	localparam int CAP_MAX = (CAP_C > KEY_MAX) ? CAP_C : KEY_MAX;
	localparam int FL_W    = $clog2(CAP_MAX + 1);
	localparam int HS_W    = $clog2(HEADER_MAX + 1);

	mode_t             mode_q, m;
	logic              fld_q, fd;
	logic [1:0]        tok_q, tok;
	logic [FL_W-1:0]   fl_q, fl;
	logic [HS_W-1:0]   hs_q, hs;
	logic              colon_q, colon;
	logic              cut_q, cut;
	logic              drop_q, drop;

	logic [1:0]        cnt;
	res_t [2:0]        r;
	logic              do_line, do_fin, skip, hdr_line, full, ok;
	logic              fb_go;
	kind_t             fb_kind;
	logic [FL_W-1:0]   fb_cap;
	logic              accept;

	assign in_ready = !fstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (cnt != 2'd0);
	assign bundle.cnt = cnt;
	assign bundle.res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_LINE_START;
			fld_q   <= 1'b0;
			tok_q   <= '0;
			fl_q    <= '0;
			hs_q    <= '0;
			colon_q <= 1'b0;
			cut_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= m;
			fld_q   <= fd;
			tok_q   <= tok;
			fl_q    <= fl;
			hs_q    <= hs;
			colon_q <= colon;
			cut_q   <= cut;
			drop_q  <= drop;
		end
	end

	always_comb begin
		m        = mode_q;
		fd       = fld_q;
		tok      = tok_q;
		fl       = fl_q;
		hs       = hs_q;
		colon    = colon_q;
		cut      = cut_q;
		drop     = drop_q;
		cnt      = 2'd0;
		r        = '0;
		do_line  = 1'b0;
		do_fin   = 1'b0;
		skip     = 1'b0;
		hdr_line = 1'b0;
		full     = 1'b0;
		ok       = 1'b0;
		fb_go    = 1'b0;
		fb_kind  = K_METHOD;
		fb_cap   = '0;

		if (in_byte == CH_NUL) begin
			do_fin = 1'b1;
		end else begin
			unique case (mode_q)
				M_LINE_START: begin
					if (in_byte == CH_LF) begin
						m = M_LINE_START;
					end else if (in_byte == CH_CR) begin
						m = M_BLANK;
					end else begin
						m       = fd ? M_KEY : M_REQ_GAP;
						fl      = '0;
						do_line = 1'b1;
					end
				end
				M_BLANK: begin
					if (in_byte == CH_LF) begin
						m  = M_BODY;
						fl = '0;
					end
				end
				M_BODY: begin
					r[cnt] = mk_res(K_BODY, in_byte, fl == '0, 6'd0, 1'b0, 6'd0, drop);
					cnt    = cnt + 2'd1;
					fl     = FL_W'(1);
				end
				default: begin
					do_line = 1'b1;
				end
			endcase

			if (do_line) begin
				hdr_line = (m == M_KEY) || (m == M_VALUE_LEAD) || (m == M_VALUE);
				full     = hs >= HS_W'(HEADER_MAX);
				if (in_byte == CH_LF) begin
					if (hdr_line) begin
						ok = colon && !full;
						if (colon && !ok) begin
							drop = 1'b1;
						end
						r[cnt] = mk_res(K_HDR_END, 8'd0, 1'b0, 6'(hs), ok, 6'd0, drop);
						cnt    = cnt + 2'd1;
						if (ok) begin
							hs = hs + HS_W'(1);
						end
					end else begin
						fd = 1'b1;
					end
					m     = M_LINE_START;
					cut   = 1'b0;
					colon = 1'b0;
					fl    = '0;
				end else if (cut) begin
					skip = 1'b1;
				end else if (in_byte == CH_CR) begin
					cut = 1'b1;
				end else if (hdr_line) begin
					if (m == M_KEY) begin
						if (in_byte == CH_COLON) begin
							colon = 1'b1;
							m     = M_VALUE_LEAD;
							fl    = '0;
						end else if (!full) begin
							fb_go   = 1'b1;
							fb_kind = K_KEY;
							fb_cap  = FL_W'(KEY_MAX);
						end
					end else if (!((m == M_VALUE_LEAD) && (in_byte == CH_SPACE))) begin
						m = M_VALUE;
						if (!full) begin
							fb_go   = 1'b1;
							fb_kind = K_VALUE;
							fb_cap  = FL_W'(VALUE_MAX);
						end
					end
				end else begin
					if (in_byte == CH_SPACE) begin
						if (m == M_REQ_TOKEN) begin
							m = M_REQ_GAP;
							if (tok == 2'd3) begin
								cut = 1'b1;
							end
						end
					end else begin
						if (m != M_REQ_TOKEN) begin
							if (tok == 2'd3) begin
								cut  = 1'b1;
								skip = 1'b1;
							end else begin
								tok = tok + 2'd1;
								fl  = '0;
								m   = M_REQ_TOKEN;
							end
						end
						if (!skip) begin
							fb_go = 1'b1;
							case (tok)
								2'd1: begin
									fb_kind = K_METHOD;
									fb_cap  = FL_W'(METHOD_MAX);
								end
								2'd2: begin
									fb_kind = K_PATH;
									fb_cap  = FL_W'(PATH_MAX_LEN);
								end
								default: begin
									fb_kind = K_VERSION;
									fb_cap  = FL_W'(VERSION_MAX);
								end
							endcase
						end
					end
				end
			end

			if (fb_go) begin
				if (fl < fb_cap) begin
					r[cnt] = mk_res(fb_kind, in_byte, fl == '0,
						hdr_line ? 6'(hs) : 6'd0, 1'b0, 6'd0, drop);
					cnt    = cnt + 2'd1;
					fl     = fl + FL_W'(1);
				end else begin
					drop = 1'b1;
				end
			end

			if (in_last) begin
				do_fin = 1'b1;
			end
		end

		if (do_fin) begin
			if ((m == M_KEY) || (m == M_VALUE_LEAD) || (m == M_VALUE)) begin
				ok = colon && (hs < HS_W'(HEADER_MAX));
				if (colon && !ok) begin
					drop = 1'b1;
				end
				r[cnt] = mk_res(K_HDR_END, 8'd0, 1'b0, 6'(hs), ok, 6'd0, drop);
				cnt    = cnt + 2'd1;
				if (ok) begin
					hs = hs + HS_W'(1);
				end
			end
			r[cnt] = mk_res(K_MSG_END, 8'd0, 1'b0, 6'd0, 1'b0, 6'(hs), drop);
			cnt    = cnt + 2'd1;
			m      = M_LINE_START;
			fd     = 1'b0;
			tok    = '0;
			fl     = '0;
			hs     = '0;
			colon  = 1'b0;
			cut    = 1'b0;
			drop   = 1'b0;
		end

		if (cnt != 2'd0) begin
			r[cnt - 2'd1].run_last = 1'b1;
		end
	end

endmodule

### rtl/htok_fifo.sv
// ----------------------------------------------------------------------------
// htok_fifo: bundle queue
// Short queue of result bundles between the classifier and the output stage.
// ----------------------------------------------------------------------------
module htok_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  htok_pkg::bundle_t    wr_data,
	input  logic                 pop,
	output htok_pkg::bundle_t    rd_data,
	output htok_pkg::fifo_stat_t stat
);
	import htok_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	bundle_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wptr_q, rptr_q;
	logic [CNT_W-1:0]   count_q;

	assign rd_data    = mem_q[rptr_q];
	assign stat.full  = count_q == CNT_W'(FIFO_DEPTH);
	assign stat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/htok_back.sv
// ----------------------------------------------------------------------------
// htok_back: result serializer
// Holds one bundle and hands its results out one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module htok_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  htok_pkg::bundle_t    rd_data,
	input  htok_pkg::fifo_stat_t fstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output htok_pkg::res_t       out_res
);
	import htok_pkg::*;

	bundle_t     hold_q;
	logic [1:0]  pos_q;
	logic        hv_q;
	logic        out_acc, at_end;

	assign out_valid = hv_q;
	assign out_res   = hold_q.res[pos_q];
	assign out_acc   = hv_q && out_ready;
	assign at_end    = pos_q == (hold_q.cnt - 2'd1);
	assign pop       = !fstat.empty && (!hv_q || (out_acc && at_end));

	always_ff @(posedge clk) begin
		if (pop) begin
			hold_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q  <= 1'b0;
			pos_q <= '0;
		end else if (pop) begin
			hv_q  <= 1'b1;
			pos_q <= '0;
		end else if (out_acc) begin
			if (at_end) begin
				hv_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

endmodule

### rtl/http_request_tokenizer_top.sv
// ----------------------------------------------------------------------------
// http_request_tokenizer_top: HTTP request tokenizer
// Tags request bytes as method, path, version, header key/value or body.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request byte per beat, tlast on the final buffer byte.
//   m_axis carries zero to three tagged results per input byte; tlast marks
//   the last result of that byte, tuser holds the kind.
//   Throughput: one input beat per cycle, set by the classifier state machine;
//   a byte with n results takes n output beats, and a four-entry
//   bundle queue absorbs the difference before s_axis_tready drops.
//   Path: a byte's bundle is registered in the queue, then in the output stage.
//   Reset: parser returns to the start of a request line, queue and output
//   stage empty. A message end also returns the parser to that state.
//   Output stall: results wait in the output stage and queue; input keeps
//   flowing until the queue fills.
// ----------------------------------------------------------------------------
module http_request_tokenizer_top #(
	parameter int METHOD_MAX   = htok_pkg::METHOD_MAX_DEF,
	parameter int PATH_MAX_LEN = htok_pkg::PATH_MAX_LEN_DEF,
	parameter int VERSION_MAX  = htok_pkg::VERSION_MAX_DEF,
	parameter int KEY_MAX      = htok_pkg::KEY_MAX_DEF,
	parameter int VALUE_MAX    = htok_pkg::VALUE_MAX_DEF,
	parameter int HEADER_MAX   = htok_pkg::HEADER_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte[7:0]
	input  logic        s_axis_tlast,  // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // data[7:0], first_of_field[8], header_index[14:9],
	                                   // header_ok[15], header_total[21:16], truncated[22]
	output logic [2:0]  m_axis_tuser,  // kind[2:0]
	output logic        m_axis_tlast   // run_last
);
	import htok_pkg::*;

	bundle_t    wr_bundle, rd_bundle;
	fifo_stat_t fstat;
	logic       push, pop;
	res_t       res;

	htok_front #(
		.METHOD_MAX   (METHOD_MAX),
		.PATH_MAX_LEN (PATH_MAX_LEN),
		.VERSION_MAX  (VERSION_MAX),
		.KEY_MAX      (KEY_MAX),
		.VALUE_MAX    (VALUE_MAX),
		.HEADER_MAX   (HEADER_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.push     (push),
		.bundle   (wr_bundle),
		.fstat    (fstat)
	);

	htok_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (rd_bundle),
		.stat    (fstat)
	);

	htok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_data   (rd_bundle),
		.fstat     (fstat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {1'b0, res.trunc, res.total, res.ok, res.idx, res.first, res.data};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.run_last;

`ifndef ASSERT_OFF
	a_end_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == K_HDR_END || m_axis_tuser == K_MSG_END)
		|-> m_axis_tdata[8:0] == 9'd0)
		else $error("end marker carries field data");

	a_ok_only_hdr_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != K_HDR_END |-> !m_axis_tdata[15])
		else $error("header_ok outside header end");

	a_total_only_msg_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != K_MSG_END |-> m_axis_tdata[21:16] == 6'd0)
		else $error("header_total outside message end");

	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fstat.full && fstat.empty))
		else $error("queue full and empty at once");
`endif

endmodule

### sim/http_request_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_request_tokenizer_checker: tag predictor and result checker
// Watches both stream channels of the tokenizer. Each accepted input beat runs
// through a local copy of the request parser. The tags it produces are queued,
// and each output beat is checked field by field against the oldest queued tag.
// ----------------------------------------------------------------------------
module http_request_tokenizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [7:0]  s_data,
	input  logic        s_last,
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [23:0] m_data,
	input  logic [2:0]  m_user,
	input  logic        m_last,
	output int          mismatch_count,
	output int          tags_due
);
	import htok_pkg::*;

	localparam int REPORT_MAX = 10;

	// parser copy
	mode_t      pm;
	bit         req_line_done;
	logic [1:0] tok_num;
	int         flen;
	int         hdr_count;
	bit         colon_seen;
	bit         line_cut;
	bit         dropped;

	res_t beat_tags[3];
	int   beat_tag_cnt;
	res_t tag_q[$];

	task automatic reset_parser();
		pm            = M_LINE_START;
		req_line_done = 1'b0;
		tok_num       = 2'd0;
		flen          = 0;
		hdr_count     = 0;
		colon_seen    = 1'b0;
		line_cut      = 1'b0;
		dropped       = 1'b0;
	endtask

	task automatic add_tag(kind_t k, logic [7:0] d, logic f, logic [5:0] idx, logic ok,
			logic [5:0] total);
		res_t r;
		if (beat_tag_cnt < 3) begin
			r.kind     = k;
			r.data     = d;
			r.first    = f;
			r.idx      = idx;
			r.ok       = ok;
			r.total    = total;
			r.trunc    = dropped;
			r.run_last = 1'b0;
			beat_tags[beat_tag_cnt] = r;
			beat_tag_cnt++;
		end
	endtask

	task automatic field_byte(kind_t k, int cap, logic [7:0] b, logic [5:0] idx);
		if (flen < cap) begin
			add_tag(k, b, flen == 0, idx, 1'b0, 6'd0);
			flen++;
		end else begin
			dropped = 1'b1;
		end
	endtask

	function automatic bit in_header();
		return pm == M_KEY || pm == M_VALUE_LEAD || pm == M_VALUE;
	endfunction

	task automatic close_header();
		bit ok;
		ok = colon_seen && hdr_count < HEADER_MAX_DEF;
		if (colon_seen && !ok)
			dropped = 1'b1;
		add_tag(K_HDR_END, 8'd0, 1'b0, 6'(hdr_count), ok, 6'd0);
		if (ok)
			hdr_count++;
	endtask

	task automatic clear_line();
		pm         = M_LINE_START;
		line_cut   = 1'b0;
		colon_seen = 1'b0;
		flen       = 0;
	endtask

	task automatic request_byte(logic [7:0] b);
		if (b == CH_SPACE) begin
			if (pm == M_REQ_TOKEN) begin
				pm = M_REQ_GAP;
				if (tok_num == 2'd3)
					line_cut = 1'b1;
			end
		end else if (pm != M_REQ_TOKEN && tok_num == 2'd3) begin
			line_cut = 1'b1;
		end else begin
			if (pm != M_REQ_TOKEN) begin
				tok_num++;
				flen = 0;
				pm   = M_REQ_TOKEN;
			end
			case (tok_num)
				2'd1: field_byte(K_METHOD, METHOD_MAX_DEF, b, 6'd0);
				2'd2: field_byte(K_PATH, PATH_MAX_LEN_DEF, b, 6'd0);
				2'd3: field_byte(K_VERSION, VERSION_MAX_DEF, b, 6'd0);
				default: ;
			endcase
		end
	endtask

	task automatic header_byte(logic [7:0] b);
		bit full;
		full = hdr_count >= HEADER_MAX_DEF;
		if (pm == M_KEY) begin
			if (b == CH_COLON) begin
				colon_seen = 1'b1;
				pm         = M_VALUE_LEAD;
				flen       = 0;
			end else if (!full) begin
				field_byte(K_KEY, KEY_MAX_DEF, b, 6'(hdr_count));
			end
		end else if (!(pm == M_VALUE_LEAD && b == CH_SPACE)) begin
			pm = M_VALUE;
			if (!full)
				field_byte(K_VALUE, VALUE_MAX_DEF, b, 6'(hdr_count));
		end
	endtask

	task automatic line_byte(logic [7:0] b);
		if (b == CH_LF) begin
			if (in_header())
				close_header();
			else
				req_line_done = 1'b1;
			clear_line();
		end else if (!line_cut) begin
			if (b == CH_CR)
				line_cut = 1'b1;
			else if (in_header())
				header_byte(b);
			else
				request_byte(b);
		end
	endtask

	task automatic end_message();
		if (in_header())
			close_header();
		add_tag(K_MSG_END, 8'd0, 1'b0, 6'd0, 1'b0, 6'(hdr_count));
		reset_parser();
	endtask

	task automatic tag_byte(logic [7:0] b, logic last);
		beat_tag_cnt = 0;
		if (b == CH_NUL) begin
			end_message();
		end else begin
			case (pm)
				M_LINE_START: begin
					if (b == CH_CR) begin
						pm = M_BLANK;
					end else if (b != CH_LF) begin
						pm   = req_line_done ? M_KEY : M_REQ_GAP;
						flen = 0;
						line_byte(b);
					end
				end
				M_BLANK: begin
					if (b == CH_LF) begin
						pm   = M_BODY;
						flen = 0;
					end
				end
				M_BODY: begin
					add_tag(K_BODY, b, flen == 0, 6'd0, 1'b0, 6'd0);
					flen = 1;
				end
				default: line_byte(b);
			endcase
			if (last)
				end_message();
		end
		if (beat_tag_cnt > 0)
			beat_tags[beat_tag_cnt - 1].run_last = 1'b1;
		for (int i = 0; i < beat_tag_cnt; i++)
			tag_q.push_back(beat_tags[i]);
	endtask

	task automatic check_tag();
		res_t want;
		res_t got;
		bit   bad;
		got.kind     = kind_t'(m_user);
		got.data     = m_data[7:0];
		got.first    = m_data[8];
		got.idx      = m_data[14:9];
		got.ok       = m_data[15];
		got.total    = m_data[21:16];
		got.trunc    = m_data[22];
		got.run_last = m_last;
		if (tag_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("unexpected beat: kind=%0d data=%h tdata=%h last=%b",
					m_user, got.data, m_data, m_last);
		end else begin
			want = tag_q.pop_front();
			bad = m_data[23] != 1'b0 || got.kind != want.kind || got.data != want.data ||
				got.first != want.first || got.idx != want.idx || got.ok != want.ok ||
				got.total != want.total || got.trunc != want.trunc ||
				got.run_last != want.run_last;
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX) begin
					$display("mismatch exp: kind=%0d data=%h first=%b idx=%0d",
						want.kind, want.data, want.first, want.idx);
					$display("    ok=%b total=%0d trunc=%b last=%b",
						want.ok, want.total, want.trunc, want.run_last);
					$display("         got: kind=%0d data=%h first=%b idx=%0d",
						got.kind, got.data, got.first, got.idx);
					$display("    ok=%b total=%0d trunc=%b last=%b pad=%b",
						got.ok, got.total, got.trunc, got.run_last, m_data[23]);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_parser();
			tag_q.delete();
			mismatch_count = 0;
		end else begin
			if (m_valid && m_ready)
				check_tag();
			if (s_valid && s_ready)
				tag_byte(s_data, s_last);
		end
		tags_due = tag_q.size();
	end

endmodule

### sim/tb_http_request_tokenizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_request_tokenizer_top: stimulus and verdict for the tokenizer
// Streams a short directed request set, then full-table, over-length and random
// requests mixed with noise, with random gaps on both channels. Checking is
// done by the attached checker.
// ----------------------------------------------------------------------------
module tb_http_request_tokenizer_top;
	import htok_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int ITEM_COUNT   = 260;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} in_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid;
	logic        s_ready;
	logic [7:0]  s_data;
	logic        s_last;
	logic        m_valid;
	logic        m_ready;
	logic [23:0] m_data;
	logic [2:0]  m_user;
	logic        m_last;

	int       mismatch_count;
	int       tags_due;
	int       idle_cycles = 0;
	in_beat_t byte_q[$];

	http_request_tokenizer_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last)
	);

	http_request_tokenizer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_valid        (s_valid),
		.s_ready        (s_ready),
		.s_data         (s_data),
		.s_last         (s_last),
		.m_valid        (m_valid),
		.m_ready        (m_ready),
		.m_data         (m_data),
		.m_user         (m_user),
		.m_last         (m_last),
		.mismatch_count (mismatch_count),
		.tags_due       (tags_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_valid && s_ready) || (m_valid && m_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic put_byte(logic [7:0] b, logic l);
		in_beat_t e;
		e.b = b;
		e.l = l;
		byte_q.push_back(e);
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i], 1'b0);
	endtask

	task automatic put_crlf();
		put_byte(CH_CR, 1'b0);
		put_byte(CH_LF, 1'b0);
	endtask

	function automatic logic [7:0] text_char(bit colon_ok, bit space_ok);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(1, 255));
		end while (c == CH_LF || c == CH_CR || (!colon_ok && c == CH_COLON) ||
			(!space_ok && c == CH_SPACE));
		return c;
	endfunction

	task automatic put_text(int len, bit colon_ok, bit space_ok);
		for (int i = 0; i < len; i++)
			put_byte(text_char(colon_ok, space_ok), 1'b0);
	endtask

	task automatic put_spaces(int len);
		for (int i = 0; i < len; i++)
			put_byte(CH_SPACE, 1'b0);
	endtask

	// ordinary request with random content and occasional defects
	task automatic put_request();
		int  n_hdr;
		int  sel;
		bit  open_line;
		if ($urandom_range(0, 5) == 0)
			put_byte(CH_LF, 1'b0);
		put_text(($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6),
			1'b1, 1'b0);
		put_spaces($urandom_range(1, 3));
		put_text(($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 12), 1'b1, 1'b0);
		put_spaces($urandom_range(1, 3));
		put_text(($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8),
			1'b1, 1'b0);
		if ($urandom_range(0, 5) == 0) begin
			put_spaces($urandom_range(1, 2));
			put_text($urandom_range(1, 4), 1'b1, 1'b0);
		end
		if ($urandom_range(0, 2) != 0)
			put_byte(CH_CR, 1'b0);
		if ($urandom_range(0, 6) == 0)
			put_text($urandom_range(1, 3), 1'b1, 1'b1);
		put_byte(CH_LF, 1'b0);
		if ($urandom_range(0, 6) == 0)
			put_byte(CH_LF, 1'b0);
		n_hdr = $urandom_range(0, 4);
		open_line = 1'b0;
		for (int h = 0; h < n_hdr; h++) begin
			sel = $urandom_range(0, 9);
			put_text(($urandom_range(0, 9) == 0) ? $urandom_range(47, 52) : $urandom_range(1, 8),
				1'b0, 1'b1);
			if (sel == 1)
				put_byte(CH_CR, 1'b0);
			if (sel != 0) begin
				put_byte(CH_COLON, 1'b0);
				put_spaces($urandom_range(0, 2));
				put_text($urandom_range(0, 10), 1'b1, 1'b1);
			end
			if (h == n_hdr - 1 && $urandom_range(0, 5) == 0) begin
				open_line = 1'b1;
			end else begin
				if ($urandom_range(0, 3) != 0)
					put_byte(CH_CR, 1'b0);
				put_byte(CH_LF, 1'b0);
			end
		end
		if (!open_line && $urandom_range(0, 5) != 0) begin
			put_crlf();
			for (int i = $urandom_range(0, 8); i > 0; i--)
				put_byte(8'($urandom_range(1, 255)), 1'b0);
		end
		case ($urandom_range(0, 2))
			0: put_byte(CH_NUL, 1'b0);
			1: put_byte(CH_NUL, 1'b1);
			default: put_byte(text_char(1'b1, 1'b1), 1'b1);
		endcase
	endtask

	task automatic put_noise();
		for (int i = $urandom_range(5, 20); i > 0; i--)
			put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
	endtask

	// over-length method and version, then more headers than the table holds
	task automatic put_full_table();
		put_text(METHOD_MAX_DEF + 1, 1'b1, 1'b0);
		put_str(" / ");
		put_text(VERSION_MAX_DEF + 1, 1'b1, 1'b0);
		put_crlf();
		for (int h = 0; h < HEADER_MAX_DEF + 1; h++)
			put_str("k:\n");
		put_str("ab:c\n");
		put_str("x\n");
		put_byte(CH_NUL, 1'b0);
	endtask

	task automatic build_stimulus();
		// single byte request ended by the buffer mark
		put_byte(8'hFF, 1'b1);
		// blank first line, then body
		put_crlf();
		put_str("Z");
		put_byte(CH_NUL, 1'b0);
		// space runs and a fourth token
		put_str("M  P V X\n");
		put_str("k: v\n");
		// carriage return hides the colon
		put_str("n");
		put_byte(CH_CR, 1'b0);
		put_str(":\n");
		put_crlf();
		put_str("b");
		put_byte(CH_NUL, 1'b1);
		put_full_table();
		while (byte_q.size() < ITEM_COUNT) begin
			if ($urandom_range(0, 5) == 0)
				put_noise();
			else
				put_request();
		end
	endtask

	initial begin
		int gap;
		s_valid = 1'b0;
		s_data  = 8'd0;
		s_last  = 1'b0;
		build_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < byte_q.size(); i++) begin
			if (i == byte_q.size() / 2) begin
				s_valid <= 1'b0;
				@(negedge clk);
				while (tags_due != 0) @(negedge clk);
			end
			gap = ((i / 50) % 3 == 2) ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				s_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_valid <= 1'b1;
			s_data  <= byte_q[i].b;
			s_last  <= byte_q[i].l;
			@(posedge clk);
			while (!s_ready) @(posedge clk);
			@(negedge clk);
		end
		s_valid <= 1'b0;
		while (tags_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int gap;
		int n;
		m_ready = 1'b0;
		n = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = ((n / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_ready <= 1'b1;
			@(posedge clk);
			while (!m_valid) @(posedge clk);
			@(negedge clk);
			n++;
		end
	end

endmodule
